[hw/rtl/mvsm_pkg.sv]
// Shared types and constants for the multi-voice sample mixer.
package mvsm_pkg;

	localparam int VOICES_DEF      = 8;
	localparam int SLOTS_DEF       = 16;
	localparam int VOLUME_FULL_DEF = 128;
	localparam int STORE_WORDS_DEF = 65536;

	localparam int ACT_W  = 3;
	localparam int ADDR_W = 16;
	localparam int BYTE_W = 8;
	localparam int SLOT_W = 4;
	localparam int LEN_W  = 17;
	localparam int GAIN_W = 8;
	localparam int VNUM_W = 3;
	localparam int STAT_W = 2;
	localparam int ACC_W  = 16;

	localparam logic [ACT_W-1:0] ACT_WRITE     = 3'd0;
	localparam logic [ACT_W-1:0] ACT_DEFINE    = 3'd1;
	localparam logic [ACT_W-1:0] ACT_VOLUME    = 3'd2;
	localparam logic [ACT_W-1:0] ACT_PLAY      = 3'd3;
	localparam logic [ACT_W-1:0] ACT_LOOP      = 3'd4;
	localparam logic [ACT_W-1:0] ACT_STOP      = 3'd5;
	localparam logic [ACT_W-1:0] ACT_STOP_LOOP = 3'd6;
	localparam logic [ACT_W-1:0] ACT_TICK      = 3'd7;

	localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
	localparam logic [STAT_W-1:0] ST_UNLOADED = 2'd1;
	localparam logic [STAT_W-1:0] ST_NO_VOICE = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_READ,
		S_ACC,
		S_SONG,
		S_OUT
	} state_t;

endpackage

[hw/rtl/multi_voice_sample_mixer_unit.sv]
// Top level of the multi-voice sample mixer.
// channel | dir | fields
// s_axis  | in  | tuser: action
//         |     | tdata: mem_address, sample_byte, sound_slot, sample_length,
//         |     |        gain_in, voice_number, song_sample, song_valid
// m_axis  | out | tdata: status, voice_taken, mixed_sample
// cfg     | in  | song_gain write
// Table actions pass the scan and output states; play/loop scan every voice; a tick
// reads then accumulates each voice in turn, set by the single sample-store read port.
// Reset clears slot, voice and control state; the sample store is not cleared.
// The input is taken only when no request is in work; the output register holds a
// result until taken while the next request may already be accepted.
module multi_voice_sample_mixer_unit
	import mvsm_pkg::*;
#(
	parameter int VOICES      = VOICES_DEF,
	parameter int SLOTS       = SLOTS_DEF,
	parameter int VOLUME_FULL = VOLUME_FULL_DEF,
	parameter int STORE_WORDS = STORE_WORDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// action[2:0]
	input  logic [ACT_W-1:0] s_axis_tuser,
	// mem_address[15:0] sample_byte[23:16] sound_slot[27:24] sample_length[44:28]
	// gain_in[52:45] voice_number[55:53] song_sample[63:56] song_valid[64]
	input  logic [71:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// status[1:0] voice_taken[4:2] mixed_sample[12:5]
	output logic [15:0] m_axis_tdata,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata
);
	localparam int VI_W = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int VC_W = $clog2(VOICES + 1);
	localparam int SI_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int MA_W = $clog2(STORE_WORDS);

	logic [BYTE_W-1:0] store_mem [STORE_WORDS];
	logic [ADDR_W-1:0] slot_start_q  [SLOTS];
	logic [LEN_W-1:0]  slot_len_q    [SLOTS];
	logic [GAIN_W-1:0] slot_gain_q   [SLOTS];
	logic [SLOTS-1:0]  slot_loaded_q;
	logic [VOICES-1:0] v_active_q, v_repeat_q;
	logic [SLOT_W-1:0] v_slot_q [VOICES];
	logic [GAIN_W-1:0] v_gain_q [VOICES];
	logic [LEN_W-1:0]  v_pos_q  [VOICES];
	logic [GAIN_W-1:0] song_gain_q;

	state_t state_q, state_d;
	logic [64:0] req_q;
	logic [ACT_W-1:0] act_q;
	logic [VC_W-1:0] idx_q;
	logic signed [ACC_W-1:0] sum_q;
	logic [STAT_W-1:0] status_q;
	logic [VI_W-1:0] taken_q;
	logic best_ok_q;
	logic [VI_W-1:0] best_q;
	logic [LEN_W-1:0] best_left_q;
	logic free_ok_q, loop_hit_q;
	logic [VI_W-1:0] free_q;
	logic [BYTE_W-1:0] rd_byte_s1;
	logic contrib_q;
	logic [BYTE_W-1:0] scale_byte;
	logic [GAIN_W-1:0] scale_gain;
	logic signed [ACC_W-1:0] scaled_s1;

	logic [ACT_W-1:0]  r_act;
	logic [ADDR_W-1:0] r_addr;
	logic [BYTE_W-1:0] r_byte;
	logic [SLOT_W-1:0] r_slot;
	logic [LEN_W-1:0]  r_len;
	logic [GAIN_W-1:0] r_gain;
	logic [VNUM_W-1:0] r_vnum;
	logic [BYTE_W-1:0] r_song;
	logic r_song_on, slot_ok;
	logic [SI_W-1:0] r_si;
	logic [VI_W-1:0] vi;
	logic [SI_W-1:0] vs;
	logic [LEN_W-1:0] vlen, vleft, rd_pos;
	logic out_full_q;
	logic [15:0] out_q;
	logic signed [ACC_W-1:0] mix_total;
	logic signed [ACC_W-1:0] clamped;

	assign r_act = act_q;
	assign r_addr = req_q[15:0];
	assign r_byte = req_q[23:16];
	assign r_slot = req_q[27:24];
	assign r_len = req_q[44:28];
	assign r_gain = req_q[52:45];
	assign r_vnum = req_q[55:53];
	assign r_song = req_q[63:56];
	assign r_song_on = req_q[64];
	assign slot_ok = 32'(r_slot) < SLOTS;
	assign r_si = SI_W'(r_slot);
	assign vi = VI_W'(idx_q);
	assign vs = SI_W'(v_slot_q[vi]);
	assign vlen = slot_len_q[vs];
	assign vleft = (v_pos_q[vi] >= vlen) ? '0 : vlen - v_pos_q[vi];
	// a looping voice at its end restarts from the first sample
	assign rd_pos = (v_pos_q[vi] >= vlen) ? '0 : v_pos_q[vi];

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_full_q;
	assign m_axis_tdata = out_q;

	assign scale_byte = (state_q == S_SONG || state_q == S_OUT) ? r_song : rd_byte_s1;
	assign scale_gain = (state_q == S_SONG || state_q == S_OUT) ? song_gain_q : v_gain_q[vi];

	mvsm_scaler #(.VOLUME_FULL(VOLUME_FULL)) u_scaler (
		.clk(clk), .sample(scale_byte), .gain(scale_gain), .scaled_s1(scaled_s1)
	);

	assign mix_total = sum_q + (r_song_on ? scaled_s1 : 16'sd0);

	always_comb begin
		clamped = mix_total;
		if (mix_total > 16'sd127) clamped = 16'sd127;
		if (mix_total < -16'sd128) clamped = -16'sd128;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (s_axis_tvalid) state_d = S_SCAN;
			S_SCAN: if (r_act == ACT_TICK) state_d = S_READ;
				else if ((r_act == ACT_PLAY || r_act == ACT_LOOP) && slot_ok &&
					slot_loaded_q[r_si] && idx_q != VC_W'(VOICES)) state_d = S_SCAN;
				else state_d = S_OUT;
			S_READ: state_d = (idx_q == VC_W'(VOICES)) ? S_SONG : S_ACC;
			S_ACC: state_d = S_READ;
			S_SONG: state_d = S_OUT;
			S_OUT: if (!out_full_q || m_axis_tready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && s_axis_tvalid) begin
			req_q <= s_axis_tdata[64:0];
			act_q <= s_axis_tuser;
		end
		if (state_q == S_SCAN && r_act == ACT_WRITE)
			store_mem[MA_W'(r_addr)] <= r_byte;
		rd_byte_s1 <= store_mem[MA_W'(slot_start_q[vs] + rd_pos)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_full_q <= 1'b0;
			out_q <= '0;
			song_gain_q <= 8'd128;
			slot_loaded_q <= '0;
			v_active_q <= '0;
			v_repeat_q <= '0;
			idx_q <= '0;
			sum_q <= '0;
			status_q <= ST_OK;
			taken_q <= '0;
			best_ok_q <= 1'b0;
			best_q <= '0;
			best_left_q <= '0;
			free_ok_q <= 1'b0;
			loop_hit_q <= 1'b0;
			free_q <= '0;
			contrib_q <= 1'b0;
			for (int i = 0; i < SLOTS; i++) begin
				slot_start_q[i] <= '0;
				slot_len_q[i] <= '0;
				slot_gain_q[i] <= GAIN_W'(VOLUME_FULL);
			end
			for (int i = 0; i < VOICES; i++) begin
				v_slot_q[i] <= '0;
				v_gain_q[i] <= '0;
				v_pos_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cfg_we) song_gain_q <= cfg_wdata;
			case (state_q)
				S_IDLE: begin
					idx_q <= '0;
					sum_q <= '0;
					status_q <= ST_OK;
					taken_q <= '0;
					best_ok_q <= 1'b0;
					free_ok_q <= 1'b0;
					loop_hit_q <= 1'b0;
					contrib_q <= 1'b0;
				end
				S_SCAN: begin
					case (r_act)
						ACT_DEFINE: if (!slot_ok) status_q <= ST_UNLOADED;
							else begin
								slot_start_q[r_si] <= r_addr;
								slot_len_q[r_si] <= r_len;
								slot_gain_q[r_si] <= GAIN_W'(VOLUME_FULL);
								slot_loaded_q[r_si] <= 1'b1;
							end
						ACT_VOLUME: if (!slot_ok) status_q <= ST_UNLOADED;
							else slot_gain_q[r_si] <= (32'(r_gain) > VOLUME_FULL) ?
								GAIN_W'(VOLUME_FULL) : r_gain;
						ACT_STOP: if (32'(r_vnum) < VOICES) begin
								v_active_q[VI_W'(r_vnum)] <= 1'b0;
								v_repeat_q[VI_W'(r_vnum)] <= 1'b0;
								v_pos_q[VI_W'(r_vnum)] <= '0;
							end
						ACT_STOP_LOOP: for (int i = 0; i < VOICES; i++)
								if (v_active_q[i] && v_repeat_q[i] && v_slot_q[i] == r_slot) begin
									v_active_q[i] <= 1'b0;
									v_repeat_q[i] <= 1'b0;
									v_pos_q[i] <= '0;
								end
						ACT_PLAY, ACT_LOOP: begin
							if (!slot_ok || !slot_loaded_q[r_si]) status_q <= ST_UNLOADED;
							else if (idx_q != VC_W'(VOICES)) begin
								idx_q <= idx_q + 1'b1;
								if (r_act == ACT_LOOP && !loop_hit_q && v_active_q[vi] &&
									v_repeat_q[vi] && v_slot_q[vi] == r_slot) begin
									loop_hit_q <= 1'b1;
									taken_q <= vi;
								end
								if (!free_ok_q && !v_active_q[vi]) begin
									free_ok_q <= 1'b1;
									free_q <= vi;
								end
								if (!v_repeat_q[vi] && (!best_ok_q || vleft < best_left_q)) begin
									best_ok_q <= 1'b1;
									best_q <= vi;
									best_left_q <= vleft;
								end
							end else if (!loop_hit_q) begin
								if (!free_ok_q && !best_ok_q) status_q <= ST_NO_VOICE;
								else begin
									v_slot_q[free_ok_q ? free_q : best_q] <= r_slot;
									v_pos_q[free_ok_q ? free_q : best_q] <= '0;
									v_gain_q[free_ok_q ? free_q : best_q] <= slot_gain_q[r_si];
									v_repeat_q[free_ok_q ? free_q : best_q] <= (r_act == ACT_LOOP);
									v_active_q[free_ok_q ? free_q : best_q] <= 1'b1;
									taken_q <= free_ok_q ? free_q : best_q;
								end
							end
						end
						default: ;
					endcase
				end
				S_READ: begin
					contrib_q <= 1'b0;
					if (idx_q != VC_W'(VOICES) && v_active_q[vi]) begin
						if (!slot_loaded_q[vs]) v_active_q[vi] <= 1'b0;
						else if (v_pos_q[vi] >= vlen) begin
							if (!v_repeat_q[vi]) v_active_q[vi] <= 1'b0;
							else v_pos_q[vi] <= '0;
						end
					end
				end
				S_ACC: begin
					if (v_active_q[vi] && slot_loaded_q[vs] && v_pos_q[vi] < vlen) begin
						contrib_q <= 1'b1;
						v_pos_q[vi] <= v_pos_q[vi] + 1'b1;
					end
					idx_q <= idx_q + 1'b1;
				end
				default: ;
			endcase
			if (state_q == S_ACC && contrib_q) sum_q <= sum_q + scaled_s1;
			if (state_q == S_READ && contrib_q) sum_q <= sum_q + scaled_s1;
			if (state_q == S_OUT && state_d == S_IDLE) begin
				out_full_q <= 1'b1;
				out_q <= {3'b0,
					(r_act == ACT_TICK) ? 8'(clamped + 16'sd128) : 8'd128,
					3'(taken_q), status_q};
			end else if (out_full_q && m_axis_tready) begin
				out_full_q <= 1'b0;
			end
		end
	end
endmodule

[hw/rtl/mvsm_scaler.sv]
// Registered (byte-128)*gain/VOLUME_FULL with truncation toward zero.
module mvsm_scaler
	import mvsm_pkg::*;
#(
	parameter int VOLUME_FULL = VOLUME_FULL_DEF
) (
	input  logic                     clk,
	input  logic [BYTE_W-1:0]        sample,
	input  logic [GAIN_W-1:0]        gain,
	output logic signed [ACC_W-1:0]  scaled_s1
);
	// reciprocal multiply, exact for magnitudes below 2^15 and divisors up to 255
	localparam int RECIP_SH = 24;
	localparam int RECIP    = ((1 << RECIP_SH) + VOLUME_FULL - 1) / VOLUME_FULL;
	localparam int PROD_W   = BYTE_W + GAIN_W + 2;

	logic signed [BYTE_W:0]     centered;
	logic signed [BYTE_W+GAIN_W+1:0] prod;
	logic [BYTE_W+GAIN_W+1:0]   mag;
	logic [BYTE_W+GAIN_W+1:0]   quo;
	logic [PROD_W+RECIP_SH:0]   recip_prod;

	always_comb begin
		centered = $signed({1'b0, sample}) - $signed(9'd128);
		prod = centered * $signed({1'b0, gain});
		mag = prod[BYTE_W+GAIN_W+1] ? -prod : prod;
		recip_prod = mag * (RECIP_SH+1)'(RECIP);
		quo = recip_prod[RECIP_SH +: PROD_W];
	end

	always_ff @(posedge clk) begin
		scaled_s1 <= prod[BYTE_W+GAIN_W+1] ? -$signed(ACC_W'(quo)) : $signed(ACC_W'(quo));
	end
endmodule

[tb/tb_multi_voice_sample_mixer_unit.sv]
// Testbench for the multi-voice sample mixer: directed and random requests checked against a predictor.
`timescale 1ns / 1ps

module tb_multi_voice_sample_mixer_unit;
	import mvsm_pkg::*;

	localparam int NV = VOICES_DEF;
	localparam int NS = SLOTS_DEF;
	localparam int VFULL = VOLUME_FULL_DEF;
	localparam int SETTLE = 3 * NV + 12;
	localparam int CYCLE_LIMIT = 600000;

	typedef struct packed {
		logic [ACT_W-1:0]  action;
		logic [ADDR_W-1:0] addr;
		logic [BYTE_W-1:0] byte_val;
		logic [SLOT_W-1:0] slot;
		logic [LEN_W-1:0]  len;
		logic [GAIN_W-1:0] gain;
		logic [VNUM_W-1:0] vnum;
		logic [7:0]        song;
		logic              song_on;
	} mix_req_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [2:0]        voice;
		logic [7:0]        mixed;
	} mix_res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [ACT_W-1:0] s_axis_tuser = '0;
	logic [71:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic        cfg_we = 1'b0;
	logic [7:0]  cfg_wdata = '0;

	multi_voice_sample_mixer_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tuser(s_axis_tuser), .s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always #4 clk = ~clk;

	// predictor state
	logic [7:0]        pcm_mem [0:STORE_WORDS_DEF-1];
	bit                pcm_written [0:STORE_WORDS_DEF-1];
	logic [ADDR_W-1:0] slot_start [NS];
	logic [LEN_W-1:0]  slot_len [NS];
	logic [GAIN_W-1:0] slot_gain [NS];
	bit                slot_loaded [NS];
	bit                v_active [NV];
	bit                v_repeat [NV];
	logic [SLOT_W-1:0] v_slot [NV];
	logic [GAIN_W-1:0] v_gain [NV];
	logic [LEN_W-1:0]  v_pos [NV];
	logic [7:0]        song_gain;

	mix_res_t pending_results[$];
	int fails = 0;
	int n_items = 0;
	int n_ticks = 0;
	int n_results = 0;
	int burst_left = 0;
	int cycles = 0;

	function automatic int scaled(logic [7:0] b, logic [7:0] g);
		int c;
		c = int'(b) - 128;
		return (c * int'(g)) / VFULL;
	endfunction

	function automatic int choose_voice();
		int best;
		logic [LEN_W-1:0] best_left, left, len;
		best = -1;
		best_left = '0;
		for (int v = 0; v < NV; v++)
			if (!v_active[v])
				return v;
		for (int v = 0; v < NV; v++) begin
			if (v_repeat[v])
				continue;
			len = slot_len[v_slot[v]];
			left = (v_pos[v] >= len) ? '0 : len - v_pos[v];
			if (best < 0 || left < best_left) begin
				best = v;
				best_left = left;
			end
		end
		return best;
	endfunction

	function automatic logic [7:0] mix_voices(logic [7:0] song, logic song_on);
		int sum;
		logic [SLOT_W-1:0] s;
		logic [ADDR_W-1:0] a;
		sum = 0;
		for (int v = 0; v < NV; v++) begin
			if (!v_active[v])
				continue;
			s = v_slot[v];
			if (!slot_loaded[s]) begin
				v_active[v] = 0;
				continue;
			end
			if (v_pos[v] >= slot_len[s]) begin
				if (!v_repeat[v]) begin
					v_active[v] = 0;
					continue;
				end
				v_pos[v] = '0;
				if (slot_len[s] == 0)
					continue;
			end
			a = slot_start[s] + v_pos[v][ADDR_W-1:0];
			sum += scaled(pcm_mem[a], v_gain[v]);
			v_pos[v] = v_pos[v] + 1'b1;
		end
		if (song_on)
			sum += scaled(song, song_gain);
		if (sum > 127)
			sum = 127;
		if (sum < -128)
			sum = -128;
		return 8'(sum + 128);
	endfunction

	function automatic mix_res_t apply_request(mix_req_t r);
		mix_res_t res;
		int v;
		bit found;
		res.status = ST_OK;
		res.voice = '0;
		res.mixed = 8'd128;
		case (r.action)
			ACT_WRITE: begin
				pcm_mem[r.addr] = r.byte_val;
				pcm_written[r.addr] = 1;
			end
			ACT_DEFINE: begin
				slot_start[r.slot] = r.addr;
				slot_len[r.slot] = r.len;
				slot_gain[r.slot] = 8'(VFULL);
				slot_loaded[r.slot] = 1;
			end
			ACT_VOLUME: slot_gain[r.slot] = (r.gain > VFULL) ? 8'(VFULL) : r.gain;
			ACT_PLAY, ACT_LOOP: begin
				found = 0;
				if (!slot_loaded[r.slot]) begin
					res.status = ST_UNLOADED;
				end else begin
					if (r.action == ACT_LOOP)
						for (int i = 0; i < NV && !found; i++)
							if (v_active[i] && v_repeat[i] && v_slot[i] == r.slot) begin
								res.voice = 3'(i);
								found = 1;
							end
					if (!found) begin
						v = choose_voice();
						if (v < 0) begin
							res.status = ST_NO_VOICE;
						end else begin
							v_slot[v] = r.slot;
							v_pos[v] = '0;
							v_gain[v] = slot_gain[r.slot];
							v_repeat[v] = (r.action == ACT_LOOP);
							v_active[v] = 1;
							res.voice = 3'(v);
						end
					end
				end
			end
			ACT_STOP: begin
				v_active[r.vnum] = 0;
				v_repeat[r.vnum] = 0;
				v_pos[r.vnum] = '0;
			end
			ACT_STOP_LOOP: begin
				for (int i = 0; i < NV; i++)
					if (v_active[i] && v_repeat[i] && v_slot[i] == r.slot) begin
						v_active[i] = 0;
						v_repeat[i] = 0;
						v_pos[i] = '0;
					end
			end
			default: res.mixed = mix_voices(r.song, r.song_on);
		endcase
		return res;
	endfunction

	function automatic mix_req_t random_req(logic [ACT_W-1:0] act);
		mix_req_t r;
		r.action = act;
		r.addr = 16'($urandom);
		r.byte_val = 8'($urandom);
		r.slot = 4'($urandom);
		r.len = 17'($urandom);
		r.gain = 8'($urandom);
		r.vnum = 3'($urandom);
		r.song = 8'($urandom);
		r.song_on = 1'($urandom);
		return r;
	endfunction

	task automatic send_req(mix_req_t r);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		s_axis_tuser <= r.action;
		s_axis_tdata <= {7'b0, r.song_on, r.song, r.vnum, r.gain, r.len, r.slot,
			r.byte_val, r.addr};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		pending_results.push_back(apply_request(r));
		n_items++;
		if (r.action == ACT_TICK)
			n_ticks++;
		burst_left--;
	endtask

	// Make sure every byte the next tick reads has been written first.
	task automatic send_tick(mix_req_t r);
		logic [SLOT_W-1:0] s;
		logic [LEN_W-1:0] p;
		logic [ADDR_W-1:0] a;
		mix_req_t w;
		for (int v = 0; v < NV; v++) begin
			if (!v_active[v])
				continue;
			s = v_slot[v];
			if (!slot_loaded[s])
				continue;
			p = v_pos[v];
			if (p >= slot_len[s]) begin
				if (!v_repeat[v] || slot_len[s] == 0)
					continue;
				p = '0;
			end
			a = slot_start[s] + p[ADDR_W-1:0];
			if (!pcm_written[a]) begin
				w = random_req(ACT_WRITE);
				w.addr = a;
				send_req(w);
			end
		end
		r.action = ACT_TICK;
		send_req(r);
	endtask

	task automatic send_op(logic [ACT_W-1:0] act, logic [3:0] slot, logic [15:0] addr,
		logic [16:0] len, logic [7:0] val);
		mix_req_t r;
		r = random_req(act);
		r.slot = slot;
		r.addr = addr;
		r.len = len;
		r.gain = val;
		r.byte_val = val;
		r.vnum = 3'(slot);
		if (act == ACT_TICK)
			send_tick(r);
		else
			send_req(r);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		wait (pending_results.size() == 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_song_gain(logic [7:0] g);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= g;
		@(posedge clk);
		cfg_we <= 1'b0;
		song_gain = g;
	endtask

	task automatic test_empty_mix();
		mix_req_t r;
		r = random_req(ACT_TICK);
		r.song_on = 0;
		send_tick(r);
		r.song_on = 1;
		r.song = 8'd0;
		send_tick(r);
		r.song = 8'd255;
		send_tick(r);
	endtask

	task automatic test_slot_table();
		send_op(ACT_PLAY, 4'd3, 16'd0, 17'd0, 8'd0);
		send_op(ACT_VOLUME, 4'd3, 16'd0, 17'd0, 8'd255);
		send_op(ACT_DEFINE, 4'd3, 16'hFFFE, 17'd4, 8'd0);
		send_op(ACT_WRITE, 4'd0, 16'hFFFE, 17'd0, 8'd255);
		send_op(ACT_WRITE, 4'd0, 16'hFFFF, 17'd0, 8'd0);
		send_op(ACT_VOLUME, 4'd3, 16'd0, 17'd0, 8'd64);
		send_op(ACT_PLAY, 4'd3, 16'd0, 17'd0, 8'd0);
		send_op(ACT_LOOP, 4'd3, 16'd0, 17'd0, 8'd0);
		send_op(ACT_LOOP, 4'd3, 16'd0, 17'd0, 8'd0);
		send_op(ACT_DEFINE, 4'd4, 16'd100, 17'd0, 8'd0);
		send_op(ACT_LOOP, 4'd4, 16'd0, 17'd0, 8'd0);
		repeat (5) send_op(ACT_TICK, 4'd0, 16'd0, 17'd0, 8'd0);
		send_op(ACT_DEFINE, 4'd3, 16'd7, 17'd65536, 8'd0);
		send_op(ACT_TICK, 4'd0, 16'd0, 17'd0, 8'd0);
		send_op(ACT_STOP, 4'd0, 16'd0, 17'd0, 8'd0);
		send_op(ACT_STOP_LOOP, 4'd3, 16'd0, 17'd0, 8'd0);
		send_op(ACT_TICK, 4'd0, 16'd0, 17'd0, 8'd0);
	endtask

	task automatic test_voice_stealing();
		for (int v = 0; v < NV; v++)
			send_op(ACT_STOP, 4'(v), 16'd0, 17'd0, 8'd0);
		send_op(ACT_DEFINE, 4'd5, 16'd16, 17'd3, 8'd0);
		send_op(ACT_DEFINE, 4'd6, 16'd64, 17'd30, 8'd0);
		repeat (7) send_op(ACT_PLAY, 4'd6, 16'd0, 17'd0, 8'd0);
		send_op(ACT_TICK, 4'd0, 16'd0, 17'd0, 8'd0);
		send_op(ACT_PLAY, 4'd5, 16'd0, 17'd0, 8'd0);
		send_op(ACT_PLAY, 4'd5, 16'd0, 17'd0, 8'd0);
		for (int v = 0; v < NV; v++)
			send_op(ACT_DEFINE, 4'(8 + v), 16'(v * 8), 17'(v + 1), 8'd0);
		for (int v = 0; v < NV; v++)
			send_op(ACT_LOOP, 4'(8 + v), 16'd0, 17'd0, 8'd0);
		send_op(ACT_PLAY, 4'd5, 16'd0, 17'd0, 8'd0);
		repeat (3) send_op(ACT_TICK, 4'd0, 16'd0, 17'd0, 8'd0);
	endtask

	// loop_heavy biases toward loops and definitions so that voices mostly end up looping;
	// count includes the store writes sent ahead of ticks
	task automatic test_random_traffic(int count, bit loop_heavy);
		mix_req_t r;
		int pick;
		int stop_at;
		stop_at = n_items + count;
		while (n_items < stop_at) begin
			pick = $urandom_range(0, 99);
			if (loop_heavy)
				r = random_req(pick < 10 ? ACT_WRITE : pick < 25 ? ACT_DEFINE :
					pick < 50 ? ACT_LOOP : pick < 58 ? ACT_PLAY : pick < 62 ? ACT_STOP_LOOP :
					pick < 65 ? ACT_VOLUME : ACT_TICK);
			else
				r = random_req(pick < 12 ? ACT_WRITE : pick < 22 ? ACT_DEFINE :
					pick < 30 ? ACT_VOLUME : pick < 45 ? ACT_PLAY : pick < 55 ? ACT_LOOP :
					pick < 61 ? ACT_STOP : pick < 66 ? ACT_STOP_LOOP : ACT_TICK);
			if (r.action == ACT_DEFINE) begin
				pick = $urandom_range(0, 49);
				r.len = pick == 0 ? 17'd0 : pick == 1 ? 17'd65536 : pick == 2 ? 17'h1FFFF :
					pick == 3 ? 17'($urandom) : 17'($urandom_range(1, 40));
			end
			if (r.action == ACT_TICK)
				send_tick(r);
			else
				send_req(r);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			n_results++;
			if (pending_results.size() == 0) begin
				fails++;
				if (fails <= 10)
					$display("unexpected result %h", m_axis_tdata);
			end else begin
				mix_res_t want;
				want = pending_results.pop_front();
				if (m_axis_tdata[1:0] !== want.status || m_axis_tdata[4:2] !== want.voice ||
						m_axis_tdata[12:5] !== want.mixed) begin
					fails++;
					if (fails <= 10)
						$display("mismatch at result %0d: status %0d/%0d voice %0d/%0d mix %0d/%0d",
							n_results, want.status, m_axis_tdata[1:0], want.voice,
							m_axis_tdata[4:2], want.mixed, m_axis_tdata[12:5]);
				end
			end
		end
	end

	// receiver stalls: the stall mode is redrawn periodically from the cycle counter
	int stall_mode = 0;
	always @(posedge clk) begin
		if (cycles % 150 == 0)
			stall_mode <= $urandom_range(0, 2);
		case (stall_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= 1'($urandom);
			default: m_axis_tready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < NS; i++) begin
			slot_start[i] = '0;
			slot_len[i] = '0;
			slot_gain[i] = 8'(VFULL);
			slot_loaded[i] = 0;
		end
		for (int i = 0; i < NV; i++) begin
			v_active[i] = 0;
			v_repeat[i] = 0;
			v_slot[i] = '0;
			v_gain[i] = '0;
			v_pos[i] = '0;
		end
		song_gain = 8'd128;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_mix();
		test_slot_table();
		test_voice_stealing();
		write_song_gain(8'd0);
		test_random_traffic(280, 0);
		write_song_gain(8'd255);
		test_random_traffic(280, 1);
		write_song_gain(8'($urandom_range(1, 254)));
		test_random_traffic(280, 0);
		write_song_gain(8'd128);
		test_empty_mix();
		drain();

		$display("%0d requests (%0d ticks) checked, %0d results, %0d mismatches",
			n_items, n_ticks, n_results, fails);
		$display("covered slot table, play/loop/steal, stops and song gain 0/128/255");
		if (fails == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

[files.f]
hw/rtl/mvsm_pkg.sv
hw/rtl/mvsm_scaler.sv
hw/rtl/multi_voice_sample_mixer_unit.sv
tb/tb_multi_voice_sample_mixer_unit.sv
